[rtl/core/spq_pkg.sv]
// Shared types and codes for the three-class strict priority queue.
// Used by spq_ctrl, spq_dpath and strict_priority_three_class_queue; no dependencies.
package spq_pkg;

  localparam int unsigned NUM_CLASSES = 3;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CLASS_EMERGENCY = 2'd0,
    CLASS_PASSENGER = 2'd1,
    CLASS_CARGO     = 2'd2,
    CLASS_UNKNOWN   = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    STATUS_QUEUED  = 3'd0,
    STATUS_FULL    = 3'd1,
    STATUS_UNKNOWN = 3'd2,
    STATUS_SERVED  = 3'd3,
    STATUS_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    STATE_IDLE,
    STATE_EXEC,
    STATE_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
    logic load_result;
  } cmd_t;

endpackage

[rtl/core/strict_priority_three_class_queue.sv]
// Three-class strict priority queue of tags (emergency, passenger, cargo).
// out_valid_o rises after the EXEC and RESULT states that follow acceptance of an input;
// RESULT holds while an earlier result is not taken. One transaction at a time passes
// capture, registered tag-store read and result load; input is taken while a result waits.
// Reset clears the pointers, occupancy counts and handshake state; tag stores keep contents.
module strict_priority_three_class_queue #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [1:0]  priority_class_i,
  input  logic [15:0] flight_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [1:0]  served_class_o,
  output logic [15:0] served_tag_o
);

  spq_pkg::cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  spq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operation_i      (operation_i),
    .priority_class_i (priority_class_i),
    .flight_tag_i     (flight_tag_i),
    .status_o         (status_o),
    .served_class_o   (served_class_o),
    .served_tag_o     (served_tag_o)
  );

endmodule

[rtl/core/spq_ctrl.sv]
// Controller state machine of the priority queue: handshakes and datapath commands.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::cmd_t cmd_o
);

  spq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::STATE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      spq_pkg::STATE_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = spq_pkg::STATE_EXEC;
        end
      end
      spq_pkg::STATE_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = spq_pkg::STATE_RESULT;
      end
      spq_pkg::STATE_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = spq_pkg::STATE_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::STATE_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/spq_dpath.sv]
// Datapath of the priority queue: tag stores, pointers, occupancy counts and result register.
// Depends on spq_pkg; driven by commands from spq_ctrl.
module spq_dpath #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::cmd_t cmd_i,
  input  logic          operation_i,
  input  logic [1:0]    priority_class_i,
  input  logic [15:0]   flight_tag_i,
  output logic [2:0]    status_o,
  output logic [1:0]    served_class_o,
  output logic [15:0]   served_tag_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NC    = spq_pkg::NUM_CLASSES;

  logic                 op_q;
  logic [1:0]           cls_q;
  logic [TAG_WIDTH-1:0] tag_q;

  logic [PTR_W-1:0]     head_q [NC];
  logic [PTR_W-1:0]     tail_q [NC];
  logic [CNT_W-1:0]     cnt_q  [NC];
  logic [TAG_WIDTH-1:0] rdata  [NC];

  logic [NC-1:0]        full, nonempty, pick, wr_en, rd_en;
  logic                 sel_full;
  spq_pkg::status_e     res_status_d, res_status_q;
  logic [1:0]           res_class_d, res_class_q;
  logic [TAG_WIDTH-1:0] tag_sel;

  logic [2:0]           status_q;
  logic [1:0]           served_class_q;
  logic [15:0]          served_tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      cls_q <= priority_class_i;
      tag_q <= TAG_WIDTH'(flight_tag_i);
    end
  end

  always_comb begin
    sel_full     = 1'b0;
    res_status_d = spq_pkg::STATUS_EMPTY;
    res_class_d  = spq_pkg::CLASS_EMERGENCY;
    for (int c = 0; c < NC; c++) begin
      full[c]     = (cnt_q[c] == CNT_W'(QUEUE_DEPTH));
      nonempty[c] = (cnt_q[c] != '0);
      pick[c]     = 1'b0;
    end
    for (int c = 0; c < NC; c++) begin
      if (nonempty[c] && (pick == '0)) begin
        pick[c] = 1'b1;
      end
      if (cls_q == 2'(c)) begin
        sel_full = full[c];
      end
    end
    for (int c = 0; c < NC; c++) begin
      wr_en[c] = cmd_i.execute && (op_q == spq_pkg::OP_ENQUEUE) &&
                 (cls_q == 2'(c)) && !full[c];
      rd_en[c] = cmd_i.execute && (op_q == spq_pkg::OP_DEQUEUE) && pick[c];
      if (pick[c]) begin
        res_class_d = 2'(c);
      end
    end
    if (op_q == spq_pkg::OP_ENQUEUE) begin
      res_class_d = spq_pkg::CLASS_EMERGENCY;
      if (cls_q == spq_pkg::CLASS_UNKNOWN) begin
        res_status_d = spq_pkg::STATUS_UNKNOWN;
      end else if (sel_full) begin
        res_status_d = spq_pkg::STATUS_FULL;
      end else begin
        res_status_d = spq_pkg::STATUS_QUEUED;
      end
    end else if (nonempty != '0) begin
      res_status_d = spq_pkg::STATUS_SERVED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NC; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else begin
      for (int c = 0; c < NC; c++) begin
        if (wr_en[c]) begin
          tail_q[c] <= (tail_q[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q[c] + 1'b1;
          cnt_q[c]  <= cnt_q[c] + 1'b1;
        end
        if (rd_en[c]) begin
          head_q[c] <= (head_q[c] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q[c] + 1'b1;
          cnt_q[c]  <= cnt_q[c] - 1'b1;
        end
      end
    end
  end

  for (genvar g = 0; g < NC; g++) begin : g_store
    logic [TAG_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (wr_en[g]) begin
        mem[tail_q[g]] <= tag_q;
      end
      if (rd_en[g]) begin
        rdata_q <= mem[head_q[g]];
      end
    end

    assign rdata[g] = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_status_q <= res_status_d;
      res_class_q  <= res_class_d;
    end
  end

  always_comb begin
    case (res_class_q)
      spq_pkg::CLASS_EMERGENCY: tag_sel = rdata[0];
      spq_pkg::CLASS_PASSENGER: tag_sel = rdata[1];
      default:                  tag_sel = rdata[2];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      status_q       <= res_status_q;
      served_class_q <= res_class_q;
      served_tag_q   <= (res_status_q == spq_pkg::STATUS_SERVED) ? 16'(tag_sel) : '0;
    end
  end

  assign status_o       = status_q;
  assign served_class_o = served_class_q;
  assign served_tag_o   = served_tag_q;

endmodule
